/* design/xsss_pkg.sv */
// ----------------------------------------------------------------------------
// xsss_pkg
// Shared types and constants for the X-tiled span splitter: span and burst
// transaction layouts, configuration register indexes and swizzle codes.
// ----------------------------------------------------------------------------
package xsss_pkg;

    // Field widths fixed by the transaction layouts
    localparam int X_W      = 16;
    localparam int Y_W      = 16;
    localparam int PX_W     = 12;
    localparam int ADDR_W   = 32;
    localparam int OFF_W    = 34;
    localparam int BYTES_W  = 10;
    localparam int CFG_W    = 9;
    localparam int BPL2_W   = 2;
    localparam int PITCH_W  = 9;
    localparam int SWZ_W    = 2;
    localparam int IDX_W    = 2;

    // X-tile geometry: 512 bytes by 8 rows, 4096 bytes per tile
    localparam int TILE_ROW_LOG2  = 9;
    localparam int TILE_ROWS_LOG2 = 3;
    localparam int TILE_LOG2      = TILE_ROW_LOG2 + TILE_ROWS_LOG2;
    // tile-row index and in-tile row-base split of the offset
    localparam int ROWHI_W        = OFF_W - TILE_LOG2;
    localparam int YHI_W          = Y_W - TILE_ROWS_LOG2;

    // Burst sizes
    localparam logic [BYTES_W-1:0] BURST_SWZ   = 10'd64;
    localparam logic [BYTES_W-1:0] BURST_PLAIN = 10'd512;

    // At most this many bursts leave for one span
    localparam int RESULT_CAP = 33;
    localparam int CNT_W      = $clog2(RESULT_CAP);

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_BPP_LOG2 = 2'd0;
    localparam logic [IDX_W-1:0] CFG_PITCH    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_SWIZZLE  = 2'd2;

    // Reset values
    localparam logic [BPL2_W-1:0]  BPL2_RST  = 2'd2;
    localparam logic [PITCH_W-1:0] PITCH_RST = 9'd1;

    // Swizzle kinds
    localparam logic [SWZ_W-1:0] SWZ_NONE    = 2'd0;
    localparam logic [SWZ_W-1:0] SWZ_BIT9    = 2'd1;
    localparam logic [SWZ_W-1:0] SWZ_BIT9_10 = 2'd2;
    localparam logic [SWZ_W-1:0] SWZ_BIT9_11 = 2'd3;

    // One destination row span
    typedef struct packed {
        logic [X_W-1:0]    start_x;
        logic [Y_W-1:0]    row_y;
        logic [PX_W-1:0]   span_pixels;
        logic [ADDR_W-1:0] source_row_address;
        logic              final_row;
    } span_t;

    // One write burst
    typedef struct packed {
        logic [OFF_W-1:0]   tiled_offset;
        logic [ADDR_W-1:0]  source_address;
        logic [BYTES_W-1:0] burst_bytes;
        logic               row_end;
        logic               copy_done;
        logic               span_clipped;
    } burst_t;

endpackage

/* design/xtile_swizzled_span_splitter.sv */
// ----------------------------------------------------------------------------
// xtile_swizzled_span_splitter
// Splits destination row spans into write bursts for an X-tiled surface,
// with bit-6 address swizzle on each burst offset.
// ----------------------------------------------------------------------------
// Usage:
//   span channel (span_valid / span_stall / span) takes one row span per
//   transaction. burst channel (burst_valid / burst_stall / burst) gives one
//   write burst per transaction: head burst up to the next group boundary,
//   full bursts of 64 bytes (swizzle on) or 512 bytes (swizzle off), then a
//   short tail. row_end marks the last burst of a span.
//   Configuration is written through cfg_we / cfg_index / cfg_data; the user must
//   write it only while no span is in flight, the block does not enforce this.
// Pipeline and throughput:
//   A span passes the input, setup/multiply, generator, burst and offset
//   registers in that order before its first burst is on the output; the
//   input register loads at the accept edge. The burst generator emits one
//   burst per cycle while the burst side does not stall; a span has 1 to 33
//   bursts, and the generator takes the next span as its last burst leaves.
//   The front stages take a new span every cycle while they have room.
// Reset clears all valid bits and loads the register defaults
// (4 bytes per pixel, pitch of one tile, no swizzle).
// A burst stall holds each occupied stage behind a full one; nothing is lost or
// repeated, and span_stall rises once the front stages are full.
// ----------------------------------------------------------------------------
module xtile_swizzled_span_splitter
    import xsss_pkg::*;
#(
    parameter int MAX_SPAN_BYTES  = 2048,
    parameter int MAX_PITCH_TILES = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // span channel
    input  logic                 span_valid,
    output logic                 span_stall,
    input  span_t                span,
    // burst channel
    output logic                 burst_valid,
    input  logic                 burst_stall,
    output burst_t               burst,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int LEFT_W = $clog2(MAX_SPAN_BYTES + 1);
    localparam int CMP_W  = (LEFT_W > PX_W) ? LEFT_W : PX_W;
    localparam int RM_W   = (LEFT_W > BYTES_W) ? LEFT_W : BYTES_W;
    localparam int COL_W  = X_W + 4;   // byte column incl. span length

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BPL2_W-1:0]  bpl2_reg;
    logic [PITCH_W-1:0] pitch_reg;
    logic [SWZ_W-1:0]   swz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpl2_reg  <= BPL2_RST;
            pitch_reg <= PITCH_RST;
            swz_reg   <= SWZ_NONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BPP_LOG2: bpl2_reg  <= cfg_data[BPL2_W-1:0];
                CFG_PITCH:    pitch_reg <= cfg_data[PITCH_W-1:0];
                CFG_SWIZZLE:  swz_reg   <= cfg_data[SWZ_W-1:0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake chain
    // ------------------------------------------------------------------
    logic a_valid_reg, b_valid_reg, g_valid_reg, d_valid_reg, e_valid_reg;
    logic a_ready, b_ready, g_ready, d_ready, e_ready;
    logic g_last;

    assign e_ready    = !e_valid_reg || !burst_stall;
    assign d_ready    = !d_valid_reg || e_ready;
    assign g_ready    = !g_valid_reg || (d_ready && g_last);
    assign b_ready    = !b_valid_reg || g_ready;
    assign a_ready    = !a_valid_reg || b_ready;
    assign span_stall = !a_ready;

    // ------------------------------------------------------------------
    // Stage A: input register
    // ------------------------------------------------------------------
    span_t a_span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_ready)
            a_valid_reg <= span_valid;
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && span_valid)
            a_span_reg <= span;
    end

    // ------------------------------------------------------------------
    // Stage B: clip, byte counts, tile-row multiply
    // ------------------------------------------------------------------
    logic [LEFT_W-1:0]  limit;
    logic               clip;
    logic [LEFT_W-1:0]  px_c;
    logic [LEFT_W-1:0]  left_b;
    logic [PITCH_W-1:0] pitch_sat;

    logic [LEFT_W-1:0]  b_left_reg;
    logic [COL_W-1:0]   b_colb_reg;
    logic [ROWHI_W-1:0] b_rowhi_reg;
    logic [2:0]         b_ylo_reg;
    logic [ADDR_W-1:0]  b_src_reg;
    logic               b_final_reg;
    logic               b_clip_reg;

    always_comb
    begin
        limit  = LEFT_W'(MAX_SPAN_BYTES) >> bpl2_reg;
        clip   = CMP_W'(a_span_reg.span_pixels) > CMP_W'(limit);
        px_c   = clip ? limit : LEFT_W'(a_span_reg.span_pixels);
        left_b = px_c << bpl2_reg;
        if (int'(pitch_reg) > MAX_PITCH_TILES)
            pitch_sat = PITCH_W'(MAX_PITCH_TILES);
        else
            pitch_sat = pitch_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_ready)
            b_valid_reg <= a_valid_reg && (left_b != '0);   // empty spans drop here
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_left_reg  <= left_b;
            b_colb_reg  <= COL_W'(a_span_reg.start_x) << bpl2_reg;
            b_rowhi_reg <= ROWHI_W'(a_span_reg.row_y[Y_W-1:TILE_ROWS_LOG2])
                         * ROWHI_W'(pitch_sat);
            b_ylo_reg   <= a_span_reg.row_y[TILE_ROWS_LOG2-1:0];
            b_src_reg   <= a_span_reg.source_row_address;
            b_final_reg <= a_span_reg.final_row;
            b_clip_reg  <= clip;
        end
    end

    // ------------------------------------------------------------------
    // Stage G: burst generator, while not stalled one burst per cycle
    // ------------------------------------------------------------------
    logic [LEFT_W-1:0]  g_left_reg;
    logic [COL_W-1:0]   g_colb_reg;
    logic [ROWHI_W-1:0] g_rowhi_reg;
    logic [2:0]         g_ylo_reg;
    logic [ADDR_W-1:0]  g_src_reg;
    logic               g_final_reg;
    logic               g_clip_reg;
    logic [CNT_W-1:0]   g_count_reg;

    logic [BYTES_W-1:0] full;
    logic [BYTES_W-1:0] grp_pos;
    logic [BYTES_W-1:0] room;
    logic               fits;
    logic [BYTES_W-1:0] g_bytes;

    always_comb
    begin
        full    = (swz_reg != SWZ_NONE) ? BURST_SWZ : BURST_PLAIN;
        grp_pos = BYTES_W'(g_colb_reg[TILE_ROW_LOG2-1:0]) & (full - 10'd1);
        room    = full - grp_pos;
        fits    = RM_W'(g_left_reg) <= RM_W'(room);
        g_bytes = fits ? BYTES_W'(g_left_reg) : room;
        g_last  = fits || (g_count_reg == CNT_W'(RESULT_CAP - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= 1'b0;
        else if (g_ready)
            g_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (g_ready)
        begin
            if (b_valid_reg)
            begin
                g_left_reg  <= b_left_reg;
                g_colb_reg  <= b_colb_reg;
                g_rowhi_reg <= b_rowhi_reg;
                g_ylo_reg   <= b_ylo_reg;
                g_src_reg   <= b_src_reg;
                g_final_reg <= b_final_reg;
                g_clip_reg  <= b_clip_reg;
                g_count_reg <= '0;
            end
        end
        else if (g_valid_reg && d_ready)
        begin
            g_left_reg  <= g_left_reg - LEFT_W'(g_bytes);
            g_colb_reg  <= g_colb_reg + COL_W'(g_bytes);
            g_src_reg   <= g_src_reg + ADDR_W'(g_bytes);
            g_count_reg <= g_count_reg + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Stage D: burst register
    // ------------------------------------------------------------------
    logic [COL_W-1:0]   d_colb_reg;
    logic [ROWHI_W-1:0] d_rowhi_reg;
    logic [2:0]         d_ylo_reg;
    logic [ADDR_W-1:0]  d_src_reg;
    logic [BYTES_W-1:0] d_bytes_reg;
    logic               d_end_reg;
    logic               d_done_reg;
    logic               d_clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (d_ready)
            d_valid_reg <= g_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && g_valid_reg)
        begin
            d_colb_reg  <= g_colb_reg;
            d_rowhi_reg <= g_rowhi_reg;
            d_ylo_reg   <= g_ylo_reg;
            d_src_reg   <= g_src_reg;
            d_bytes_reg <= g_bytes;
            d_end_reg   <= g_last;
            d_done_reg  <= g_last && g_final_reg;
            d_clip_reg  <= g_clip_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: tiled offset, swizzle, output register
    // ------------------------------------------------------------------
    logic [ROWHI_W-1:0] tile_hi;
    logic [OFF_W-1:0]   off_lin;
    logic               swz_bit;
    logic [OFF_W-1:0]   off_swz;
    burst_t             e_burst_reg;

    always_comb
    begin
        tile_hi = d_rowhi_reg + ROWHI_W'(d_colb_reg[COL_W-1:TILE_ROW_LOG2]);
        off_lin = {tile_hi, d_ylo_reg, d_colb_reg[TILE_ROW_LOG2-1:0]};
        unique case (swz_reg)
            SWZ_BIT9:    swz_bit = off_lin[9];
            SWZ_BIT9_10: swz_bit = off_lin[9] ^ off_lin[10];
            SWZ_BIT9_11: swz_bit = off_lin[9] ^ off_lin[11];
            default:     swz_bit = 1'b0;
        endcase
        off_swz    = off_lin;
        off_swz[6] = off_lin[6] ^ swz_bit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (e_ready)
            e_valid_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (e_ready && d_valid_reg)
        begin
            e_burst_reg.tiled_offset   <= off_swz;
            e_burst_reg.source_address <= d_src_reg;
            e_burst_reg.burst_bytes    <= d_bytes_reg;
            e_burst_reg.row_end        <= d_end_reg;
            e_burst_reg.copy_done      <= d_done_reg;
            e_burst_reg.span_clipped   <= d_clip_reg;
        end
    end

    assign burst_valid = e_valid_reg;
    assign burst       = e_burst_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // generator never runs past the burst cap
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        g_valid_reg |-> (g_count_reg <= CNT_W'(RESULT_CAP - 1)))
        else $error("burst count past cap");

    // a span in the generator always has bytes left
    a_left: assert property (@(posedge clk) disable iff (!rst_n)
        g_valid_reg |-> (g_left_reg != '0))
        else $error("generator holds an empty span");

    // a non-final burst ends exactly on a group boundary
    a_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid_reg && !d_end_reg) |->
            (((d_colb_reg[TILE_ROW_LOG2-1:0] + TILE_ROW_LOG2'(d_bytes_reg))
              & TILE_ROW_LOG2'(full - 10'd1)) == '0))
        else $error("mid-span burst ends off a group boundary");

    // copy_done only on a row-ending burst
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (burst_valid && burst.copy_done) |-> burst.row_end)
        else $error("copy_done without row_end");

    // emitted bursts are non-empty and never longer than one full burst
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid |-> (burst.burst_bytes != '0) && (burst.burst_bytes <= full))
        else $error("burst length out of range");

endmodule
